[rtl/core/aftt_pkg.sv]
// shared types, constants and codes of the auth failure throttle table
// no dependencies; compiled before every other file of the block
package aftt_pkg;

    // table size default
    localparam int unsigned BUCKET_COUNT_DEF = 16;

    // field widths
    localparam int unsigned OP_W      = 2;
    localparam int unsigned KEY_W     = 32;
    localparam int unsigned TIME_W    = 64;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned RETRY_W   = 13;
    localparam int unsigned CFG_W     = 32;
    localparam int unsigned CFG_IDX_W = 2;

    // event codes
    typedef enum logic [OP_W-1:0] {
        OP_ADMIT   = 2'd0,
        OP_SUCCESS = 2'd1,
        OP_FAILURE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd2;

    // configuration reset values
    localparam logic [31:0]      WINDOW_RST   = 32'd60000000;
    localparam logic [31:0]      COOLDOWN_RST = 32'd300000000;
    localparam logic [CNT_W-1:0] LIMIT_RST    = 8'd5;

    // retry time in seconds, rounded up and saturated
    localparam logic [31:0]        US_PER_S     = 32'd1000000;
    localparam logic [31:0]        US_ROUND     = 32'd999999;
    localparam logic [RETRY_W-1:0] RETRY_MAX    = '1;
    localparam logic [TIME_W-1:0]  RETRY_SAT_US = TIME_W'(RETRY_MAX) * TIME_W'(US_PER_S);

    // seconds by reciprocal multiply: 10^6 = 2^6 * 15625, and
    // n / 15625 = (n * RECIP_M) >> RECIP_SH exactly for n below 2^28
    localparam int unsigned DIV_W    = 34;
    localparam int unsigned DIV_SH   = 6;
    localparam int unsigned NUM_W    = DIV_W - DIV_SH;
    localparam int unsigned RECIP_W  = 29;
    localparam int unsigned RECIP_SH = 42;
    localparam int unsigned PROD_W   = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M = 29'd281474977;

    // one table entry
    typedef struct packed {
        logic              in_use;
        logic [KEY_W-1:0]  key;
        logic [TIME_W-1:0] win_start;
        logic [TIME_W-1:0] blocked_until;
        logic [CNT_W-1:0]  fail_cnt;
    } bucket_t;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic eval;
        logic decide;
        logic div;
        logic write;
        logic finish;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic op_none;
        logic scan_done;
        logic need_div;
        logic div_done;
    } status_t;

endpackage

[rtl/core/aftt_if.sv]
// valid/ready channel interfaces for event items and result items
// depends on aftt_pkg for field widths
interface aftt_in_if import aftt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [KEY_W-1:0]  peer_id;
    logic [TIME_W-1:0] now_us;

    modport source (output valid, output opcode, output peer_id, output now_us, input ready);
    modport sink   (input valid, input opcode, input peer_id, input now_us, output ready);
endinterface

interface aftt_out_if import aftt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               admitted;
    logic [RETRY_W-1:0] retry_s;

    modport source (output valid, output admitted, output retry_s, input ready);
    modport sink   (input valid, input admitted, input retry_s, output ready);
endinterface

[rtl/core/auth_failure_throttle_table_top.sv]
// top level of the auth failure throttle table
// depends on aftt_pkg, aftt_in_if, aftt_out_if, aftt_ctrl and aftt_dp
//
// usage: event items (opcode, peer_id, now_us) enter on in_ch; each gives
// exactly one result item (admitted, retry_s) on out_ch, in order.
// opcode admit asks for admission, success clears the peer's bucket,
// failure counts toward a lockout; opcode three only returns admitted.
// configuration: cfg_we, cfg_index and cfg_data write the window length,
// cooldown and failure limit; write only while idle.
// one item at a time. the scan reads one bucket per cycle and stops
// at the first bucket owned by the peer or free; an admit refused without
// saturating adds the seconds multiply, and opcode three leaves the scan
// state at once for the result.
// in_ch.ready is high only while idle, from the same edge that loads the
// result, so a new item is taken only when the last one is through.
// the result sits in an output register; a new item may be accepted while
// it waits, and a finished item holds until the register is taken.
// reset: all buckets empty, configuration at defaults, no result pending.
module auth_failure_throttle_table_top import aftt_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    aftt_in_if.sink              in_ch,
    aftt_out_if.source           out_ch
);

    cmd_t    cmd;
    status_t status;

    // controller
    aftt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath
    aftt_dp #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_opcode    (in_ch.opcode),
        .in_peer_id   (in_ch.peer_id),
        .in_now_us    (in_ch.now_us),
        .cmd          (cmd),
        .status       (status),
        .out_admitted (out_ch.admitted),
        .out_retry_s  (out_ch.retry_s)
    );

    // a refused admit always carries a nonzero retry, an admitted one zero
    a_retry_matches_admit : assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (out_ch.admitted == (out_ch.retry_s == '0)))
        else $error("retry_s disagrees with admitted");

    // the block is busy right after taking an item
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("item accepted while previous item still in work");

    // controller issues at most one command per cycle
    a_one_command : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.start, cmd.scan, cmd.eval, cmd.decide, cmd.div, cmd.write,
                  cmd.finish}))
        else $error("overlapping controller commands");

    // the divider step always follows a decide that needs it
    a_div_after_decide : assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.decide && status.need_div) |=> cmd.div)
        else $error("divider not started after refused admit");

endmodule

[rtl/core/aftt_ctrl.sv]
// sequencing state machine of the throttle table
// depends on aftt_pkg for command and status structs
module aftt_ctrl import aftt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    out_ready,
    output logic    out_valid,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_EVAL   = 7'b0000100,
        S_DECIDE = 7'b0001000,
        S_DIV    = 7'b0010000,
        S_WRITE  = 7'b0100000,
        S_FINISH = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.op_none)
                begin
                    state_next = S_FINISH;
                end
                else if (status.scan_done)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.need_div ? S_DIV : S_WRITE;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                if (status.div_done)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write  = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

[rtl/core/aftt_dp.sv]
// datapath of the throttle table: bucket memory, scan, update, retry seconds
// depends on aftt_pkg for types, widths and constants
module aftt_dp import aftt_pkg::*;
#(
    parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic [OP_W-1:0]      in_opcode,
    input  logic [KEY_W-1:0]     in_peer_id,
    input  logic [TIME_W-1:0]    in_now_us,
    input  cmd_t                 cmd,
    output status_t              status,
    output logic                 out_admitted,
    output logic [RETRY_W-1:0]   out_retry_s
);

    localparam int unsigned IDX_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
    localparam int unsigned ISS_W = $clog2(BUCKET_COUNT + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKET_COUNT - 1);
    localparam logic [ISS_W-1:0] ISS_END  = ISS_W'(BUCKET_COUNT);

    // configuration
    logic [31:0]       window_reg;
    logic [31:0]       cooldown_reg;
    logic [CNT_W-1:0]  limit_reg;

    // current item
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [TIME_W-1:0] now_reg;

    // bucket memory, entries never written read as zero
    bucket_t                 mem [BUCKET_COUNT];
    logic [BUCKET_COUNT-1:0] written_reg;
    bucket_t                 rd_word_reg;
    logic                    rd_written_reg;
    bucket_t                 rd_entry;

    // scan pipeline
    logic [ISS_W-1:0]  issue_reg;
    logic              eval_valid_reg;
    logic [IDX_W-1:0]  eval_idx_reg;
    logic [IDX_W-1:0]  oldest_idx_reg;
    logic [TIME_W-1:0] oldest_ws_reg;
    logic [IDX_W-1:0]  oldest_idx_next;
    logic [TIME_W-1:0] oldest_ws_next;
    logic              issue_done;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              hit;
    logic              scan_done;
    bucket_t           evicted;

    // selected bucket and its update
    logic [IDX_W-1:0]  sel_idx_reg;
    bucket_t           work_reg;
    logic              lock_reg;
    logic [TIME_W-1:0] diff_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [TIME_W-1:0] ws_eff;
    logic [CNT_W-1:0]  cnt_inc;
    logic [TIME_W:0]   lock_sum;
    logic [TIME_W-1:0] lock_end;
    logic              retry_sat;
    logic              need_div;

    // retry seconds
    logic [DIV_W-1:0]  rem_reg;
    logic [PROD_W-1:0] prod;
    logic              div_done;

    // result
    logic               res_admitted_reg;
    logic [RETRY_W-1:0] res_retry_reg;
    logic               out_admitted_reg;
    logic [RETRY_W-1:0] out_retry_reg;

    // configuration writes, unknown indexes ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= WINDOW_RST;
            cooldown_reg <= COOLDOWN_RST;
            limit_reg    <= LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:   window_reg   <= cfg_data;
                CFG_COOLDOWN: cooldown_reg <= cfg_data;
                CFG_LIMIT:    limit_reg    <= cfg_data[CNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // scan read port control
    assign issue_done = (issue_reg == ISS_END);
    assign rd_en      = cmd.scan && !issue_done;
    assign rd_addr    = issue_reg[IDX_W-1:0];

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[sel_idx_reg] <= work_reg;
        end
        if (rd_en)
        begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    // written flags per entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                written_reg[sel_idx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_entry = rd_written_reg ? rd_word_reg : '0;

    // entry evaluation: match or free stops the scan, else track oldest window
    always_comb
    begin
        hit             = eval_valid_reg && (!rd_entry.in_use || (rd_entry.key == key_reg));
        oldest_idx_next = oldest_idx_reg;
        oldest_ws_next  = oldest_ws_reg;
        if (eval_valid_reg &&
            ((eval_idx_reg == '0) || (rd_entry.win_start < oldest_ws_reg)))
        begin
            oldest_idx_next = eval_idx_reg;
            oldest_ws_next  = rd_entry.win_start;
        end
        scan_done         = cmd.scan && eval_valid_reg && (hit || (eval_idx_reg == LAST_IDX));
        evicted           = '0;
        evicted.win_start = now_reg;
    end

    // scan registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
        end
        else if (cmd.start)
        begin
            issue_reg      <= '0;
            eval_valid_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            eval_valid_reg <= !issue_done;
            if (!issue_done)
            begin
                issue_reg <= issue_reg + ISS_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan)
        begin
            eval_idx_reg   <= rd_addr;
            oldest_idx_reg <= oldest_idx_next;
            oldest_ws_reg  <= oldest_ws_next;
        end
    end

    // update helpers
    assign ws_eff    = work_reg.in_use ? work_reg.win_start : now_reg;
    assign cnt_inc   = (work_reg.fail_cnt != '1) ? (work_reg.fail_cnt + CNT_W'(1))
                                                 : work_reg.fail_cnt;
    assign lock_sum  = {1'b0, now_reg} + {1'b0, TIME_W'(cooldown_reg)};
    assign lock_end  = lock_sum[TIME_W] ? '1 : lock_sum[TIME_W-1:0];
    assign retry_sat = (diff_reg > RETRY_SAT_US);
    assign need_div  = (op_reg == OP_ADMIT) && lock_reg && !retry_sat;

    // rounded-up seconds: drop the 2^6 factor, multiply by the reciprocal of 15625
    assign prod     = PROD_W'(rem_reg[DIV_W-1:DIV_SH]) * PROD_W'(RECIP_M);
    assign div_done = cmd.div;

    // item, selected bucket, divider and result registers
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg           <= op_t'(in_opcode);
            key_reg          <= in_peer_id;
            now_reg          <= in_now_us;
            res_admitted_reg <= 1'b1;
            res_retry_reg    <= '0;
        end
        if (scan_done)
        begin
            if (hit)
            begin
                sel_idx_reg <= eval_idx_reg;
                work_reg    <= rd_entry;
            end
            else
            begin
                sel_idx_reg <= oldest_idx_next;
                work_reg    <= evicted;
            end
        end
        if (cmd.eval)
        begin
            lock_reg    <= (work_reg.blocked_until > now_reg);
            diff_reg    <= work_reg.blocked_until - now_reg;
            elapsed_reg <= now_reg - ws_eff;
            case (op_reg)
                OP_ADMIT:
                begin
                    if (!work_reg.in_use)
                    begin
                        work_reg.in_use    <= 1'b1;
                        work_reg.key       <= key_reg;
                        work_reg.win_start <= now_reg;
                    end
                end
                OP_SUCCESS:
                begin
                    work_reg <= '0;
                end
                OP_FAILURE:
                begin
                    if (cnt_inc >= limit_reg)
                    begin
                        work_reg.blocked_until <= lock_end;
                        work_reg.fail_cnt      <= '0;
                    end
                    else
                    begin
                        work_reg.fail_cnt <= cnt_inc;
                    end
                end
                default: ;
            endcase
        end
        // admit outcome: refuse while locked, else restart an expired window
        if (cmd.decide && (op_reg == OP_ADMIT))
        begin
            if (lock_reg)
            begin
                res_admitted_reg <= 1'b0;
                if (retry_sat)
                begin
                    res_retry_reg <= RETRY_MAX;
                end
                rem_reg <= diff_reg[DIV_W-1:0] + DIV_W'(US_ROUND);
            end
            else if (elapsed_reg > TIME_W'(window_reg))
            begin
                work_reg.win_start <= now_reg;
                work_reg.fail_cnt  <= '0;
            end
        end
        if (cmd.div)
        begin
            res_retry_reg <= prod[RECIP_SH +: RETRY_W];
        end
        if (cmd.finish)
        begin
            out_admitted_reg <= res_admitted_reg;
            out_retry_reg    <= res_retry_reg;
        end
    end

    // status to controller
    always_comb
    begin
        status           = '0;
        status.op_none   = (op_reg == OP_NONE);
        status.scan_done = scan_done;
        status.need_div  = need_div;
        status.div_done  = div_done;
    end

    assign out_admitted = out_admitted_reg;
    assign out_retry_s  = out_retry_reg;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// testbench for the auth failure throttle table: directed script, then random phases
// depends on aftt_pkg, aftt_in_if, aftt_out_if and auth_failure_throttle_table_top
module tb_top;
    import aftt_pkg::*;

    localparam int unsigned SLOTS        = BUCKET_COUNT_DEF;
    localparam int unsigned POOL         = 24;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam int unsigned REPORT_MAX   = 10;

    typedef struct packed {
        logic               admitted;
        logic [RETRY_W-1:0] retry;
    } verdict_t;

    typedef enum logic {
        ROW_EVENT,
        ROW_WRITE
    } row_kind_t;

    typedef struct {
        row_kind_t            kind;
        op_t                  op;
        logic [KEY_W-1:0]     key;
        logic [TIME_W-1:0]    now;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
        logic                 given;
        verdict_t             want;
    } script_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    aftt_in_if  in_ch ();
    aftt_out_if out_ch ();

    auth_failure_throttle_table_top #(
        .BUCKET_COUNT(SLOTS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // shadow of the bucket table and the registers
    logic              slot_busy    [SLOTS];
    logic [KEY_W-1:0]  slot_key     [SLOTS];
    logic [TIME_W-1:0] slot_start   [SLOTS];
    logic [TIME_W-1:0] slot_unblock [SLOTS];
    logic [CNT_W-1:0]  slot_fails   [SLOTS];
    logic [31:0]       win_len;
    logic [31:0]       cool_len;
    logic [CNT_W-1:0]  fail_lim;

    verdict_t          owed_verdicts [$];
    script_row_t       script [$];
    logic [KEY_W-1:0]  key_pool [POOL];
    logic [TIME_W-1:0] clock_us;
    logic              tail_quiet;
    int unsigned       mismatches;
    int unsigned       results_taken;
    int unsigned       hold_left;
    int unsigned       stall_left;
    verdict_t          head;

    // clock
    always #10 clk = ~clk;

    // hard stop
    initial
    begin
        #10_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void clear_slot(int b);
        slot_busy[b]    = 1'b0;
        slot_key[b]     = '0;
        slot_start[b]   = '0;
        slot_unblock[b] = '0;
        slot_fails[b]   = '0;
    endfunction

    // first bucket owned by the key or free, else evict the oldest window
    function automatic int pick_slot(logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
        int oldest;
        oldest = 0;
        for (int b = 0; b < SLOTS; b++)
        begin
            if (!slot_busy[b] || slot_key[b] == key)
                return b;
            if (slot_start[b] < slot_start[oldest])
                oldest = b;
        end
        clear_slot(oldest);
        slot_start[oldest] = now;
        return oldest;
    endfunction

    // apply one event to the shadow table and return its verdict
    function automatic verdict_t predict_verdict(op_t op, logic [KEY_W-1:0] key,
                                                 logic [TIME_W-1:0] now);
        verdict_t          v;
        int                b;
        logic [TIME_W-1:0] left_us;
        logic [TIME_W-1:0] secs;
        logic [TIME_W-1:0] unblock;
        v.admitted = 1'b1;
        v.retry    = '0;
        case (op)
            OP_ADMIT:
            begin
                b = pick_slot(key, now);
                if (!slot_busy[b])
                begin
                    slot_busy[b]  = 1'b1;
                    slot_key[b]   = key;
                    slot_start[b] = now;
                end
                if (slot_unblock[b] > now)
                begin
                    left_us    = slot_unblock[b] - now;
                    secs       = left_us / TIME_W'(US_PER_S)
                               + TIME_W'((left_us % TIME_W'(US_PER_S)) != 0);
                    v.admitted = 1'b0;
                    v.retry    = (secs > TIME_W'(RETRY_MAX)) ? RETRY_MAX : secs[RETRY_W-1:0];
                end
                else if (now - slot_start[b] > TIME_W'(win_len))
                begin
                    slot_start[b] = now;
                    slot_fails[b] = '0;
                end
            end
            OP_SUCCESS:
                clear_slot(pick_slot(key, now));
            OP_FAILURE:
            begin
                b = pick_slot(key, now);
                if (slot_fails[b] != '1)
                    slot_fails[b] = slot_fails[b] + CNT_W'(1);
                if (slot_fails[b] >= fail_lim)
                begin
                    unblock         = now + TIME_W'(cool_len);
                    slot_unblock[b] = (unblock < now) ? '1 : unblock;
                    slot_fails[b]   = '0;
                end
            end
            default:
                ;
        endcase
        return v;
    endfunction

    // script rows
    function automatic script_row_t ev(op_t op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now);
        script_row_t r;
        r.kind    = ROW_EVENT;
        r.op      = op;
        r.key     = key;
        r.now     = now;
        r.reg_idx = CFG_WINDOW;
        r.reg_val = '0;
        r.given   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic script_row_t ev_known(op_t op, logic [KEY_W-1:0] key,
                                             logic [TIME_W-1:0] now, logic adm,
                                             logic [RETRY_W-1:0] retry);
        script_row_t r;
        r               = ev(op, key, now);
        r.given         = 1'b1;
        r.want.admitted = adm;
        r.want.retry    = retry;
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        script_row_t r;
        r         = ev(OP_NONE, '0, '0);
        r.kind    = ROW_WRITE;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // offer one event item, wait for the handshake, record what it owes
    task automatic offer_event(op_t op, logic [KEY_W-1:0] key, logic [TIME_W-1:0] now,
                               logic given, verdict_t want);
        verdict_t    v;
        int unsigned gap;
        if (!tail_quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.peer_id <= key;
        in_ch.now_us  <= now;
        do
            @(posedge clk);
        while (!in_ch.ready);
        v = predict_verdict(op, key, now);
        owed_verdicts.push_back(given ? want : v);
    endtask

    // register write once the block has gone quiet
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        in_ch.valid <= 1'b0;
        while (owed_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_WINDOW:   win_len  = val;
            CFG_COOLDOWN: cool_len = val;
            CFG_LIMIT:    fail_lim = val[CNT_W-1:0];
            default:      ;
        endcase
    endtask

    // one register setting followed by random traffic
    task automatic run_phase(logic [31:0] win, logic [31:0] cool, logic [CNT_W-1:0] lim,
                             int unsigned step, int unsigned count);
        logic [KEY_W-1:0] key;
        int unsigned      pick;
        op_t              op;
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_COOLDOWN, cool);
        write_reg(CFG_LIMIT, CFG_W'(lim));
        key = key_pool[$urandom_range(0, POOL - 1)];
        repeat (count)
        begin
            // time mostly creeps forward, with rare jumps either way
            pick = $urandom_range(0, 199);
            if (pick < 2)
                clock_us = clock_us - TIME_W'($urandom_range(0, step * 4 + 1));
            else if (pick == 2)
                clock_us = {$urandom, $urandom};
            else if (pick == 3)
                clock_us = {32'hFFFF_FFFF, $urandom};
            else
                clock_us = clock_us + TIME_W'($urandom_range(0, step));
            // a peer tends to come back several times in a row
            pick = $urandom_range(0, 99);
            if (pick >= 90)
                key = $urandom;
            else if (pick >= 50)
                key = key_pool[$urandom_range(0, POOL - 1)];
            pick = $urandom_range(0, 99);
            if (pick < 38)
                op = OP_ADMIT;
            else if (pick < 80)
                op = OP_FAILURE;
            else if (pick < 95)
                op = OP_SUCCESS;
            else
                op = OP_NONE;
            offer_event(op, key, clock_us, 1'b0, '0);
        end
    endtask

    // result side: check each item, stall in bursts, hold off twice for long
    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            results_taken++;
            if (owed_verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: admitted=%0b retry=%0d",
                             out_ch.admitted, out_ch.retry_s);
            end
            else
            begin
                head = owed_verdicts.pop_front();
                if (head.admitted !== out_ch.admitted || head.retry !== out_ch.retry_s)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("result %0d: expected admitted=%0b retry=%0d, got %0b %0d",
                                 results_taken, head.admitted, head.retry,
                                 out_ch.admitted, out_ch.retry_s);
                end
            end
            if (results_taken == 150 || results_taken == 650)
                hold_left = 250;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end
        else if (!tail_quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    // main sequence
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_WINDOW;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.opcode  = OP_NONE;
        in_ch.peer_id = '0;
        in_ch.now_us  = '0;
        out_ch.ready  = 1'b0;
        tail_quiet    = 1'b0;
        mismatches    = 0;
        results_taken = 0;
        hold_left     = 0;
        stall_left    = 0;
        win_len       = WINDOW_RST;
        cool_len      = COOLDOWN_RST;
        fail_lim      = LIMIT_RST;
        for (int b = 0; b < SLOTS; b++)
            clear_slot(b);
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL; k++)
            key_pool[k] = $urandom;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // defaults: five failures lock the peer for 300 s
        script.push_back(ev_known(OP_ADMIT, 32'd0, 64'd0, 1'b1, 13'd0));
        for (int n = 1; n <= 5; n++)
            script.push_back(ev_known(OP_FAILURE, 32'd0, 64'(n), 1'b1, 13'd0));
        script.push_back(ev_known(OP_ADMIT, 32'd0, 64'd6, 1'b0, 13'd300));
        script.push_back(ev(OP_ADMIT, 32'd0, 64'd300_000_005));
        script.push_back(ev_known(OP_SUCCESS, 32'd0, 64'd300_000_006, 1'b1, 13'd0));
        script.push_back(ev_known(OP_NONE, '1, '1, 1'b1, 13'd0));
        // failure on a free bucket, lockout end saturates, retry saturates
        script.push_back(reg_row(CFG_LIMIT, 32'd1));
        script.push_back(ev_known(OP_FAILURE, '1, 64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 13'd0));
        script.push_back(ev_known(OP_ADMIT, '1, 64'd0, 1'b0, RETRY_MAX));
        // limit zero: every failure locks
        script.push_back(reg_row(CFG_LIMIT, 32'd0));
        script.push_back(ev_known(OP_FAILURE, 32'd1, 64'd100, 1'b1, 13'd0));
        script.push_back(ev_known(OP_ADMIT, 32'd1, 64'd100, 1'b0, 13'd300));
        // time going backwards restarts the window
        script.push_back(ev(OP_ADMIT, 32'd2, 64'd1000));
        script.push_back(ev(OP_ADMIT, 32'd2, 64'd500));
        // window of one microsecond, longest cooldown
        script.push_back(reg_row(CFG_WINDOW, 32'd1));
        script.push_back(reg_row(CFG_COOLDOWN, 32'hFFFF_FFFF));
        script.push_back(ev(OP_ADMIT, 32'd2, 64'd502));
        script.push_back(ev_known(OP_FAILURE, 32'd3, 64'd512, 1'b1, 13'd0));
        script.push_back(ev_known(OP_ADMIT, 32'd3, 64'd512, 1'b0, 13'd4295));
        script.push_back(ev(OP_SUCCESS, 32'hA5A5_5A5A, 64'h5555_AAAA_5555_AAAA));

        foreach (script[i])
        begin
            if (script[i].kind == ROW_WRITE)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                offer_event(script[i].op, script[i].key, script[i].now,
                            script[i].given, script[i].want);
        end

        // random traffic over several register settings
        clock_us = 64'd1_000_000;
        run_phase(32'd2_000_000, 32'd5_000_000, 8'd3, 20_000, 140);
        run_phase(32'd1, 32'd1, 8'd1, 3, 130);
        run_phase('1, '1, 8'd255, 50_000_000, 130);
        run_phase($urandom_range(100, 50_000), $urandom_range(1, 20_000_000),
                  CNT_W'($urandom_range(1, 6)), 5_000, 140);
        run_phase($urandom_range(1_000, 200_000), $urandom_range(1_000_000, 9_000_000),
                  8'd0, 10_000, 130);
        run_phase(32'd500, 32'd2_500_000, 8'd2, 30_000, 130);
        run_phase(WINDOW_RST, COOLDOWN_RST, LIMIT_RST, 2_000_000, 140);
        tail_quiet <= 1'b1;
        run_phase($urandom, $urandom, CNT_W'($urandom_range(1, 8)), 100_000, 160);

        // drain
        in_ch.valid <= 1'b0;
        while (owed_verdicts.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && owed_verdicts.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/aftt_pkg.sv
rtl/core/aftt_if.sv
rtl/core/aftt_ctrl.sv
rtl/core/aftt_dp.sv
rtl/core/auth_failure_throttle_table_top.sv
test/tb_top.sv
